// ----- design/brf_pkg.sv -----
// Shared constants and types for the block ring FIFO.
package brf_pkg;

    localparam int MAX_CAPACITY = 63;
    localparam int WORD_BITS    = 32;
    localparam int LEN_W        = 6;
    localparam int SLOTS        = MAX_CAPACITY + 1;
    localparam int PTR_W        = $clog2(SLOTS);
    localparam int SLOT_W       = $clog2(SLOTS + 1);
    localparam int CNT_W        = (SLOT_W > LEN_W) ? SLOT_W : LEN_W;

    localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(63);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

endpackage

// ----- design/brf_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module brf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/block_ring_fifo_unit.sv -----
// Top level of the block ring FIFO: pointers, block-run control and read sequencer.
//
//  channel   direction  handshake                      payload
//  item      in         i_start, o_busy                i_op, i_word, i_length, i_block_start
//  result    out        o_strobe (one cycle, no stall) o_data_out, o_status, o_moved,
//                                                      o_used, o_last
//  config    in         i_cfg_valid, o_cfg_ready       i_cfg_data (capacity_in_use)
//
// Write and clear items: one result the cycle after accept; one item per cycle while not busy.
// Read/peek of n words: busy while the words are read, one word per cycle from the single
// RAM read port; a zero-length or over-long read/peek gives one result and no busy.
// Reset empties the FIFO and sets capacity 63; the RAM holds no reset value.
// Results cannot be stalled by the receiver.
module block_ring_fifo_unit
    import brf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_op,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [LEN_W-1:0]     i_length,
    input  logic                 i_block_start,
    output logic                 o_strobe,
    output logic [WORD_BITS-1:0] o_data_out,
    output logic                 o_status,
    output logic [LEN_W-1:0]     o_moved,
    output logic [LEN_W-1:0]     o_used,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state               r_state, n_state;
    logic [SLOT_W-1:0]    r_slots, n_slots;
    logic [PTR_W-1:0]     r_wptr, n_wptr;
    logic [PTR_W-1:0]     r_rptr, n_rptr;
    logic [PTR_W-1:0]     r_p, n_p;
    logic [LEN_W-1:0]     r_left, n_left;
    logic                 r_drop, n_drop;
    logic [LEN_W-1:0]     r_count, n_count;
    logic [LEN_W-1:0]     r_rleft, n_rleft;
    logic [LEN_W-1:0]     r_rlen, n_rlen;
    logic [LEN_W-1:0]     r_after, n_after;
    logic                 r_o_strobe, n_o_strobe;
    logic                 r_o_sel, n_o_sel;
    logic                 r_o_status, n_o_status;
    logic [LEN_W-1:0]     r_o_moved, n_o_moved;
    logic [LEN_W-1:0]     r_o_used, n_o_used;
    logic                 r_o_last, n_o_last;

    logic                 ram_we;
    logic [PTR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 accept;
    logic                 cfg_acc;
    logic [CNT_W-1:0]     held;
    logic [CNT_W-1:0]     len_x;
    logic [CNT_W-1:0]     free_x;
    logic [PTR_W-1:0]     adv_w;
    logic [CNT_W:0]       rsum;
    logic [PTR_W-1:0]     rp_wrap;
    logic [LEN_W-1:0]     w_left;
    logic                 w_drop;
    logic [LEN_W-1:0]     w_count;
    logic                 w_last;

    function automatic logic [SLOT_W-1:0] f_slots(logic [LEN_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = CNT_W'(v);
        if (c == '0) begin
            c = CNT_W'(1);
        end else if (c > CNT_W'(MAX_CAPACITY)) begin
            c = CNT_W'(MAX_CAPACITY);
        end
        return SLOT_W'(c + CNT_W'(1));
    endfunction

    function automatic logic [CNT_W-1:0] f_used(logic [PTR_W-1:0] w, logic [PTR_W-1:0] r,
                                                logic [SLOT_W-1:0] s);
        logic [CNT_W-1:0] wx;
        logic [CNT_W-1:0] rx;
        wx = CNT_W'(w);
        rx = CNT_W'(r);
        return (w >= r) ? (wx - rx) : (wx + CNT_W'(s) - rx);
    endfunction

    function automatic logic [PTR_W-1:0] f_adv(logic [PTR_W-1:0] p, logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] nx;
        nx = SLOT_W'(p) + SLOT_W'(1);
        return (nx == s) ? '0 : nx[PTR_W-1:0];
    endfunction

    brf_ram #(
        .DEPTH (SLOTS),
        .WIDTH (WORD_BITS),
        .AW    (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (i_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_busy      = (r_state == ST_READ);
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_start;
    assign accept      = i_start && (r_state == ST_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign held    = f_used(r_wptr, r_rptr, r_slots);
    assign len_x   = CNT_W'(i_length);
    assign free_x  = CNT_W'(r_slots) - CNT_W'(1) - held;
    assign adv_w   = f_adv(r_wptr, r_slots);
    assign rsum    = (CNT_W+1)'(r_rptr) + (CNT_W+1)'(i_length);
    assign rp_wrap = (rsum >= (CNT_W+1)'(r_slots)) ? PTR_W'(rsum - (CNT_W+1)'(r_slots))
                                                     : PTR_W'(rsum);

    always_comb begin
        n_state    = r_state;
        n_slots    = r_slots;
        n_wptr     = r_wptr;
        n_rptr     = r_rptr;
        n_p        = r_p;
        n_left     = r_left;
        n_drop     = r_drop;
        n_count    = r_count;
        n_rleft    = r_rleft;
        n_rlen     = r_rlen;
        n_after    = r_after;
        n_o_strobe = 1'b0;
        n_o_sel    = 1'b0;
        n_o_status = 1'b0;
        n_o_moved  = '0;
        n_o_used   = r_o_used;
        n_o_last   = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = r_p;
        w_count    = i_block_start ? '0 : r_count;
        w_drop     = i_block_start ? (len_x > free_x) : r_drop;
        w_left     = (i_block_start ? i_length : r_left) - LEN_W'(1);
        w_last     = (w_left == '0);

        unique case (r_state)
            ST_IDLE: begin
                if (cfg_acc) begin
                    n_slots = f_slots(i_cfg_data);
                    n_wptr  = '0;
                    n_rptr  = '0;
                    n_left  = '0;
                    n_drop  = 1'b0;
                    n_count = '0;
                end else if (accept) begin
                    unique case (t_op'(i_op))
                        OP_CLEAR: begin
                            n_wptr     = '0;
                            n_rptr     = '0;
                            n_left     = '0;
                            n_drop     = 1'b0;
                            n_count    = '0;
                            n_o_strobe = 1'b1;
                            n_o_used   = '0;
                            n_o_last   = 1'b1;
                        end
                        OP_WRITE: begin
                            n_o_strobe = 1'b1;
                            priority if (i_block_start && (i_length == '0)) begin
                                n_left   = '0;
                                n_drop   = 1'b0;
                                n_count  = '0;
                                n_o_used = held[LEN_W-1:0];
                                n_o_last = 1'b1;
                            end else if (!i_block_start && (r_left == '0)) begin
                                n_o_status = 1'b1;
                                n_o_used   = held[LEN_W-1:0];
                                n_o_last   = 1'b1;
                            end else begin
                                if (w_drop || (adv_w == r_rptr)) begin
                                    n_o_status = 1'b1;
                                end else begin
                                    ram_we    = 1'b1;
                                    n_wptr    = adv_w;
                                    w_count   = w_count + LEN_W'(1);
                                    n_o_moved = w_last ? w_count : '0;
                                end
                                n_drop   = w_last ? 1'b0 : w_drop;
                                n_left   = w_left;
                                n_count  = w_count;
                                n_o_last = w_last;
                                n_o_used = LEN_W'(f_used(n_wptr, r_rptr, r_slots));
                            end
                        end
                        OP_READ, OP_PEEK: begin
                            priority if (len_x > held) begin
                                n_o_strobe = 1'b1;
                                n_o_status = 1'b1;
                                n_o_used   = held[LEN_W-1:0];
                                n_o_last   = 1'b1;
                            end else if (i_length == '0) begin
                                n_o_strobe = 1'b1;
                                n_o_used   = held[LEN_W-1:0];
                                n_o_last   = 1'b1;
                            end else begin
                                n_state = ST_READ;
                                n_p     = r_rptr;
                                n_rleft = i_length;
                                n_rlen  = i_length;
                                if (t_op'(i_op) == OP_READ) begin
                                    n_after = LEN_W'(held - len_x);
                                    n_rptr  = rp_wrap;
                                end else begin
                                    n_after = held[LEN_W-1:0];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                ram_raddr  = r_p;
                n_p        = f_adv(r_p, r_slots);
                n_rleft    = r_rleft - LEN_W'(1);
                n_o_strobe = 1'b1;
                n_o_sel    = 1'b1;
                n_o_used   = r_after;
                n_o_last   = (r_rleft == LEN_W'(1));
                n_o_moved  = (r_rleft == LEN_W'(1)) ? r_rlen : '0;
                if (r_rleft == LEN_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_slots    <= f_slots(CAP_RESET);
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_left     <= '0;
            r_drop     <= 1'b0;
            r_count    <= '0;
            r_rleft    <= '0;
            r_o_strobe <= 1'b0;
            r_o_sel    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slots    <= n_slots;
            r_wptr     <= n_wptr;
            r_rptr     <= n_rptr;
            r_left     <= n_left;
            r_drop     <= n_drop;
            r_count    <= n_count;
            r_rleft    <= n_rleft;
            r_o_strobe <= n_o_strobe;
            r_o_sel    <= n_o_sel;
        end
        r_p        <= n_p;
        r_rlen     <= n_rlen;
        r_after    <= n_after;
        r_o_status <= n_o_status;
        r_o_moved  <= n_o_moved;
        r_o_used   <= n_o_used;
        r_o_last   <= n_o_last;
    end

    assign o_strobe   = r_o_strobe;
    assign o_data_out = r_o_sel ? ram_rdata : '0;
    assign o_status   = r_o_status;
    assign o_moved    = r_o_moved;
    assign o_used     = r_o_used;
    assign o_last     = r_o_last;

endmodule

// ----- design/brf_chk.sv -----
// Port-level checker for the block ring FIFO, bound to the top level.
module brf_chk
    import brf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic [1:0]           i_op,
    input logic                 o_strobe,
    input logic [WORD_BITS-1:0] o_data_out,
    input logic                 o_status,
    input logic [LEN_W-1:0]     o_moved,
    input logic [LEN_W-1:0]     o_used,
    input logic                 o_last
);

    a_wr_clr_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == OP_WRITE || i_op == OP_CLEAR)) |=> o_strobe)
        else $error("write or clear word gave no result");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_op == OP_CLEAR) |=> (o_used == '0 && o_last && !o_status))
        else $error("clear did not empty the FIFO");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |-> (o_data_out == '0 && o_moved == '0))
        else $error("rejected word carries data or moved count");

    a_moved_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (o_moved == '0))
        else $error("moved count set before last word");

endmodule

bind block_ring_fifo_unit brf_chk u_brf_chk (.*);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench for block_ring_fifo_unit: directed and random block traffic checked against a ring mirror.
module tb;
    import brf_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 370;

    typedef struct packed {
        logic [WORD_BITS-1:0] data_out;
        logic                 status;
        logic [LEN_W-1:0]     moved;
        logic [LEN_W-1:0]     used;
        logic                 last;
    } t_fifo_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [1:0]           i_op;
    logic [WORD_BITS-1:0] i_word;
    logic [LEN_W-1:0]     i_length;
    logic                 i_block_start;
    logic                 o_strobe;
    logic [WORD_BITS-1:0] o_data_out;
    logic                 o_status;
    logic [LEN_W-1:0]     o_moved;
    logic [LEN_W-1:0]     o_used;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [LEN_W-1:0]     i_cfg_data;

    t_fifo_result         pending_results[$];
    logic [WORD_BITS-1:0] ring_mem [SLOTS];
    logic [PTR_W-1:0]     ring_wr;
    logic [PTR_W-1:0]     ring_rd;
    logic [LEN_W-1:0]     ring_cap;
    logic [LEN_W-1:0]     run_left;
    logic [LEN_W-1:0]     run_stored;
    logic                 run_drop;
    int                   err_count = 0;
    int                   cycle_count = 0;
    bit                   fast_mode = 1'b0;

    block_ring_fifo_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_op          (i_op),
        .i_word        (i_word),
        .i_length      (i_length),
        .i_block_start (i_block_start),
        .o_strobe      (o_strobe),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_moved       (o_moved),
        .o_used        (o_used),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int ring_slots();
        int c;
        c = int'(ring_cap);
        if (c == 0) c = 1;
        if (c > MAX_CAPACITY) c = MAX_CAPACITY;
        return c + 1;
    endfunction

    function automatic int ring_used();
        return (int'(ring_wr) + ring_slots() - int'(ring_rd)) % ring_slots();
    endfunction

    function automatic void ring_empty();
        ring_wr    = '0;
        ring_rd    = '0;
        run_left   = '0;
        run_drop   = 1'b0;
        run_stored = '0;
    endfunction

    function automatic void push_result(input logic [WORD_BITS-1:0] data, input logic status,
                                        input logic [LEN_W-1:0] moved, input int used,
                                        input logic last);
        t_fifo_result r;
        r.data_out = data;
        r.status   = status;
        r.moved    = moved;
        r.used     = LEN_W'(used);
        r.last     = last;
        pending_results.push_back(r);
    endfunction

    function automatic logic [WORD_BITS-1:0] random_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    function automatic void fifo_response(input t_op op, input logic [WORD_BITS-1:0] word,
                                          input logic [LEN_W-1:0] len, input logic bs);
        int               slots;
        int               held;
        int               after;
        int               p;
        int               i;
        logic             st;
        logic             lst;
        logic [LEN_W-1:0] mv;
        slots = ring_slots();
        held  = ring_used();
        case (op)
            OP_CLEAR: begin
                ring_empty();
                push_result('0, 1'b0, '0, 0, 1'b1);
            end
            OP_WRITE: begin
                if (bs && len == '0) begin
                    run_stored = '0;
                    run_left   = '0;
                    run_drop   = 1'b0;
                    push_result('0, 1'b0, '0, held, 1'b1);
                end else if (!bs && run_left == '0) begin
                    push_result('0, 1'b1, '0, held, 1'b1);
                end else begin
                    if (bs) begin
                        run_stored = '0;
                        run_drop   = (int'(len) > slots - 1 - held);
                        run_left   = len;
                    end
                    run_left = run_left - 1'b1;
                    lst      = (run_left == '0);
                    st       = 1'b1;
                    mv       = '0;
                    if (!run_drop && (int'(ring_wr) + 1) % slots != int'(ring_rd)) begin
                        ring_mem[ring_wr] = word;
                        ring_wr           = PTR_W'((int'(ring_wr) + 1) % slots);
                        run_stored        = run_stored + 1'b1;
                        st                = 1'b0;
                        if (lst) mv = run_stored;
                    end
                    if (lst) run_drop = 1'b0;
                    push_result('0, st, mv, ring_used(), lst);
                end
            end
            default: begin
                if (int'(len) > held) begin
                    push_result('0, 1'b1, '0, held, 1'b1);
                end else if (len == '0) begin
                    push_result('0, 1'b0, '0, held, 1'b1);
                end else begin
                    after = (op == OP_READ) ? held - int'(len) : held;
                    p     = int'(ring_rd);
                    for (i = 0; i < int'(len); i++) begin
                        push_result(ring_mem[p], 1'b0, (i + 1 == int'(len)) ? len : LEN_W'(0),
                                    after, i + 1 == int'(len));
                        p = (p + 1) % slots;
                    end
                    if (op == OP_READ) ring_rd = PTR_W'(p);
                end
            end
        endcase
    endfunction

    task automatic issue_command(input t_op op, input logic [WORD_BITS-1:0] word,
                                 input logic [LEN_W-1:0] len, input logic bs);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_op          <= op;
        i_word        <= word;
        i_length      <= len;
        i_block_start <= bs;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        fifo_response(op, word, len, bs);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [LEN_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        ring_cap = value;
        ring_empty();
    endtask

    always @(posedge i_clk) begin
        t_fifo_result exp_r;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: data_out %h used %0d last %b",
                       o_data_out, o_used, o_last);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_data_out !== exp_r.data_out) begin
                    $error("data_out: expected %h, actual %h", exp_r.data_out, o_data_out);
                    err_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status: expected %b, actual %b", exp_r.status, o_status);
                    err_count++;
                end
                if (o_moved !== exp_r.moved) begin
                    $error("moved: expected %0d, actual %0d", exp_r.moved, o_moved);
                    err_count++;
                end
                if (o_used !== exp_r.used) begin
                    $error("used: expected %0d, actual %0d", exp_r.used, o_used);
                    err_count++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %b, actual %b", exp_r.last, o_last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_basic_ops();
        issue_command(OP_WRITE, '0, LEN_W'(3), 1'b1);
        issue_command(OP_WRITE, '1, LEN_W'(0), 1'b0);
        issue_command(OP_WRITE, $urandom(), LEN_W'(63), 1'b0);
        issue_command(OP_PEEK, $urandom(), LEN_W'(3), 1'b0);
        issue_command(OP_READ, $urandom(), LEN_W'(2), 1'b1);
        issue_command(OP_READ, $urandom(), LEN_W'(0), 1'b0);
        issue_command(OP_PEEK, $urandom(), LEN_W'(0), 1'b0);
    endtask

    task automatic test_special_cases();
        issue_command(OP_WRITE, $urandom(), LEN_W'(0), 1'b1);
        issue_command(OP_WRITE, $urandom(), LEN_W'(5), 1'b0);
        issue_command(OP_READ, $urandom(), LEN_W'(63), 1'b0);
        issue_command(OP_PEEK, $urandom(), LEN_W'(2), 1'b0);
        // abandon a run mid-way with a new block
        issue_command(OP_WRITE, $urandom(), LEN_W'(4), 1'b1);
        issue_command(OP_WRITE, $urandom(), LEN_W'(0), 1'b0);
        issue_command(OP_WRITE, $urandom(), LEN_W'(2), 1'b1);
        issue_command(OP_WRITE, $urandom(), LEN_W'(0), 1'b0);
        issue_command(OP_PEEK, $urandom(), LEN_W'(5), 1'b0);
        issue_command(OP_CLEAR, $urandom(), LEN_W'(7), 1'b1);
        issue_command(OP_READ, $urandom(), LEN_W'(1), 1'b0);
    endtask

    task automatic test_capacity_limits();
        write_capacity(LEN_W'(0));
        issue_command(OP_WRITE, $urandom(), LEN_W'(2), 1'b1);
        issue_command(OP_WRITE, $urandom(), LEN_W'(0), 1'b0);
        issue_command(OP_WRITE, $urandom(), LEN_W'(1), 1'b1);
        issue_command(OP_READ, $urandom(), LEN_W'(1), 1'b0);
        write_capacity(LEN_W'(1));
        issue_command(OP_WRITE, $urandom(), LEN_W'(1), 1'b1);
        issue_command(OP_WRITE, $urandom(), LEN_W'(1), 1'b1);
        issue_command(OP_PEEK, $urandom(), LEN_W'(1), 1'b0);
        issue_command(OP_READ, $urandom(), LEN_W'(1), 1'b0);
    endtask

    task automatic random_traffic(input int count);
        int sent;
        int pick;
        int r;
        int len;
        int n;
        int k;
        int held;
        int cap_eff;
        t_op op;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 19) == 0) fast_mode = !fast_mode;
            held    = ring_used();
            cap_eff = ring_slots() - 1;
            pick    = $urandom_range(0, 99);
            if (pick < 45) begin
                r = $urandom_range(0, 19);
                if (r < 14) len = $urandom_range(1, (cap_eff + 2 < 8) ? cap_eff + 2 : 8);
                else if (r < 19) len = $urandom_range(1, (cap_eff + 2 < 63) ? cap_eff + 2 : 63);
                else len = $urandom_range(0, 63);
                n = len;
                if (len == 0) n = 1;
                else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, len);
                for (k = 0; k < n; k++) begin
                    issue_command(OP_WRITE, random_word(),
                                  (k == 0) ? LEN_W'(len) : LEN_W'($urandom()), k == 0);
                    if ($urandom_range(0, 24) == 0)
                        issue_command(OP_PEEK, random_word(),
                                      LEN_W'($urandom_range(0, ring_used())), 1'b0);
                end
                sent += n;
            end else if (pick < 85) begin
                r = $urandom_range(0, 19);
                if (r < 16) len = $urandom_range(0, held);
                else if (r < 19) len = held + $urandom_range(1, 3);
                else len = $urandom_range(0, 63);
                if (len > 63) len = 63;
                op = (pick < 70) ? OP_READ : OP_PEEK;
                issue_command(op, random_word(), LEN_W'(len), 1'(($urandom() & 1)));
                sent++;
            end else if (pick < 90) begin
                issue_command(OP_CLEAR, random_word(), LEN_W'($urandom()), 1'(($urandom() & 1)));
                sent++;
            end else if (pick < 97) begin
                if (run_left != '0) sent++;
                issue_command(OP_WRITE, random_word(), LEN_W'($urandom()), 1'b0);
            end else begin
                wait_drained();
            end
        end
    endtask

    task automatic test_random_traffic();
        write_capacity(LEN_W'(63));
        random_traffic(RANDOM_ITEMS / 5);
        write_capacity(LEN_W'(1));
        random_traffic(RANDOM_ITEMS / 5);
        write_capacity(LEN_W'($urandom_range(2, 12)));
        random_traffic(RANDOM_ITEMS / 5);
        write_capacity(LEN_W'($urandom_range(13, 62)));
        random_traffic(RANDOM_ITEMS / 5);
        write_capacity(LEN_W'(63));
        random_traffic(RANDOM_ITEMS / 5);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_op          <= OP_WRITE;
        i_word        <= '0;
        i_length      <= '0;
        i_block_start <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        ring_cap = CAP_RESET;
        ring_empty();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_special_cases();
        test_capacity_limits();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- block_ring_fifo_unit.f -----
design/brf_pkg.sv
design/brf_ram.sv
design/block_ring_fifo_unit.sv
design/brf_chk.sv
test/tb.sv
